// ===== sv/sh24_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sh24_pkg;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

    localparam int QUEUE_DEPTH = 2;
    localparam int WORD_BYTES = 8;
    localparam logic [3:0] FULL_COUNT = 4'd8;
    localparam logic [1:0] FIN_LAST = 2'd3;

    localparam logic CFG_KEY_LOW = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef enum logic [1:0] {
        K_ABSORB,
        K_TAIL,
        K_FULL_TAIL
    } t_kind;

    typedef struct packed {
        logic        init;
        t_kind       kind;
        logic [63:0] word;
        logic [7:0]  len;
    } t_op;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_lanes;

    typedef enum logic [2:0] {
        S_IDLE,
        S_R2,
        S_T1,
        S_FIN,
        S_DONE
    } t_state;

    function automatic t_lanes sip_round(input t_lanes v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        t_lanes      r;
        a = v.v0;
        b = v.v1;
        c = v.v2;
        d = v.v3;
        a = a + b;
        b = {b[50:0], b[63:51]};
        b = b ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]};
        d = d ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]};
        d = d ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]};
        b = b ^ c;
        c = {c[31:0], c[63:32]};
        r.v0 = a;
        r.v1 = b;
        r.v2 = c;
        r.v3 = d;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/siphash_2_4_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Keyed SipHash-2-4 over a stream of 64-bit little-endian words, one hash per
// message (tlast marks the final word, its tdata byte count 0..8 gives the
// valid low bytes). A front stage classifies each request and queues it; a
// round engine doing one SipRound per cycle, save while it waits on the
// output register, works through the queue. A non-last word takes just the
// compression rounds; a last word adds the finalization rounds and output load,
// a full last word first absorbing an extra length block. The hash sits in an
// output register, so the engine and the input side go on while it waits. Keys
// load at the first word of each message; write them only while the block is idle.
module siphash_2_4_stream #(
    parameter int QUEUE_DEPTH = sh24_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // data_word[63:0], byte_count[67:64], zero
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // hash[63:0]
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_wr_data
);

    logic [63:0]   r_key_low;
    logic [63:0]   r_key_high;
    logic          w_q_push;
    logic          w_q_ready;
    logic          w_q_valid;
    logic          w_q_pop;
    sh24_pkg::t_op w_push_op;
    sh24_pkg::t_op w_pop_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low <= 64'd0;
            r_key_high <= 64'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sh24_pkg::CFG_KEY_LOW:  r_key_low <= i_cfg_wr_data;
                sh24_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_wr_data;
                default:                r_key_low <= r_key_low;
            endcase
        end
    end

    sh24_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_data_word  (s_axis_tdata[63:0]),
        .i_byte_count (s_axis_tdata[67:64]),
        .i_last       (s_axis_tlast),
        .i_q_ready    (w_q_ready),
        .o_ready      (s_axis_tready),
        .o_push       (w_q_push),
        .o_op         (w_push_op)
    );

    sh24_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_push_op),
        .i_pop   (w_q_pop),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_op    (w_pop_op)
    );

    sh24_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_q_valid  (w_q_valid),
        .i_q_op     (w_pop_op),
        .o_q_pop    (w_q_pop),
        .o_valid    (m_axis_tvalid),
        .o_hash     (m_axis_tdata),
        .i_ready    (m_axis_tready)
    );

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> w_q_ready)
        else $error("request queued while queue full");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("engine popped an empty queue");

    a_stall_means_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_q_valid)
        else $error("input stalled with empty queue");
`endif

endmodule
`default_nettype wire

// ===== sv/sh24_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sh24_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [63:0]     i_data_word,
    input  wire logic [3:0]      i_byte_count,
    input  wire logic            i_last,
    input  wire logic            i_q_ready,
    output logic                 o_ready,
    output logic                 o_push,
    output sh24_pkg::t_op        o_op
);

    logic       r_open;
    logic [7:0] r_len;
    logic [7:0] n_len;
    logic [7:0] w_base_len;
    logic       w_full;
    logic [63:0] w_tail;

    assign o_ready = i_q_ready;
    assign o_push = i_valid && i_q_ready;

    always_comb begin
        w_full = !i_last || (i_byte_count >= sh24_pkg::FULL_COUNT);
        w_base_len = r_open ? r_len : 8'd0;
        n_len = w_base_len + (w_full ? 8'd8 : {5'd0, i_byte_count[2:0]});
        for (int i = 0; i < sh24_pkg::WORD_BYTES; i++) begin
            w_tail[8*i +: 8] = (4'(i) < i_byte_count) ? i_data_word[8*i +: 8] : 8'd0;
        end
        w_tail[63:56] = n_len;
        o_op.init = !r_open;
        o_op.len = n_len;
        if (!i_last) begin
            o_op.kind = sh24_pkg::K_ABSORB;
            o_op.word = i_data_word;
        end else if (w_full) begin
            o_op.kind = sh24_pkg::K_FULL_TAIL;
            o_op.word = i_data_word;
        end else begin
            o_op.kind = sh24_pkg::K_TAIL;
            o_op.word = w_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_len <= 8'd0;
        end else if (o_push) begin
            r_open <= !i_last;
            r_len <= n_len;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sh24_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sh24_queue #(
    parameter int DEPTH = sh24_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sh24_pkg::t_op   i_op,
    input  wire logic            i_pop,
    output logic                 o_ready,
    output logic                 o_valid,
    output sh24_pkg::t_op        o_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sh24_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/sh24_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sh24_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [63:0]     i_key_low,
    input  wire logic [63:0]     i_key_high,
    input  wire logic            i_q_valid,
    input  wire sh24_pkg::t_op   i_q_op,
    output logic                 o_q_pop,
    output logic                 o_valid,
    output logic [63:0]          o_hash,
    input  wire logic            i_ready
);

    sh24_pkg::t_state r_state;
    sh24_pkg::t_state n_state;
    sh24_pkg::t_lanes r_v;
    sh24_pkg::t_lanes n_v;
    sh24_pkg::t_lanes w_key_v;
    sh24_pkg::t_lanes w_round_in;
    sh24_pkg::t_lanes w_round_out;
    sh24_pkg::t_kind  r_kind;
    sh24_pkg::t_kind  n_kind;
    logic [63:0]      r_m;
    logic [63:0]      n_m;
    logic [7:0]       r_len;
    logic [7:0]       n_len;
    logic [1:0]       r_fin_cnt;
    logic [1:0]       n_fin_cnt;
    logic             r_out_valid;
    logic [63:0]      r_out_data;
    logic             w_out_free;
    logic             w_load_out;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_hash = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sh24_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = sh24_pkg::S_R2;
                end
            end
            sh24_pkg::S_R2: begin
                unique case (r_kind)
                    sh24_pkg::K_ABSORB:    n_state = sh24_pkg::S_IDLE;
                    sh24_pkg::K_TAIL:      n_state = sh24_pkg::S_FIN;
                    sh24_pkg::K_FULL_TAIL: n_state = sh24_pkg::S_T1;
                    default:               n_state = sh24_pkg::S_IDLE;
                endcase
            end
            sh24_pkg::S_T1: n_state = sh24_pkg::S_R2;
            sh24_pkg::S_FIN: begin
                if (r_fin_cnt == sh24_pkg::FIN_LAST) begin
                    n_state = sh24_pkg::S_DONE;
                end
            end
            sh24_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = sh24_pkg::S_IDLE;
                end
            end
            default: n_state = sh24_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop = (r_state == sh24_pkg::S_IDLE) && i_q_valid;
        w_load_out = (r_state == sh24_pkg::S_DONE) && w_out_free;
    end

    // round datapath, one SipRound per cycle except in S_DONE or when idle
    always_comb begin
        w_key_v.v0 = i_key_low ^ sh24_pkg::SIP_C0;
        w_key_v.v1 = i_key_high ^ sh24_pkg::SIP_C1;
        w_key_v.v2 = i_key_low ^ sh24_pkg::SIP_C2;
        w_key_v.v3 = i_key_high ^ sh24_pkg::SIP_C3;
        w_round_in = r_v;
        unique case (r_state)
            sh24_pkg::S_IDLE: begin
                w_round_in = i_q_op.init ? w_key_v : r_v;
                w_round_in.v3 = w_round_in.v3 ^ i_q_op.word;
            end
            sh24_pkg::S_T1: w_round_in.v3 = r_v.v3 ^ r_m;
            sh24_pkg::S_FIN: begin
                if (r_fin_cnt == 2'd0) begin
                    w_round_in.v2 = r_v.v2 ^ sh24_pkg::FIN_MARK;
                end
            end
            default: w_round_in = r_v;
        endcase
        w_round_out = sh24_pkg::sip_round(w_round_in);

        n_v = r_v;
        n_m = r_m;
        n_kind = r_kind;
        n_len = r_len;
        n_fin_cnt = r_fin_cnt;
        unique case (r_state)
            sh24_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_v = w_round_out;
                    n_m = i_q_op.word;
                    n_kind = i_q_op.kind;
                    n_len = i_q_op.len;
                end
            end
            sh24_pkg::S_R2: begin
                n_v = w_round_out;
                n_v.v0 = w_round_out.v0 ^ r_m;
                n_fin_cnt = 2'd0;
                if (r_kind == sh24_pkg::K_FULL_TAIL) begin
                    n_m = {r_len, 56'd0};
                    n_kind = sh24_pkg::K_TAIL;
                end
            end
            sh24_pkg::S_T1: n_v = w_round_out;
            sh24_pkg::S_FIN: begin
                n_v = w_round_out;
                n_fin_cnt = r_fin_cnt + 2'd1;
            end
            default: n_v = r_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_m <= n_m;
        r_kind <= n_kind;
        r_len <= n_len;
        if (w_load_out) begin
            r_out_data <= r_v.v0 ^ r_v.v1 ^ r_v.v2 ^ r_v.v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sh24_pkg::S_IDLE;
            r_fin_cnt <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin_cnt <= n_fin_cnt;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
